FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros that are shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/ctw_pkg.sv
// ----------------------------------------------------------------------------
// ctw_pkg
// Shared constants and types of the census window transform.
// ----------------------------------------------------------------------------
`default_nettype none

package ctw_pkg;

  localparam int CTW_WINDOW       = 8;
  localparam int CTW_MAX_WIDTH    = 1024;

  localparam int CTW_PIXEL_W      = 8;
  localparam int CTW_CODE_W       = 63;
  localparam int CTW_ROW_W        = 12;
  localparam int CTW_COL_W        = 10;
  localparam int CTW_WIDTH_W      = 11;
  localparam int CTW_HEIGHT_W     = 12;
  localparam int CTW_OUT_W        = 88;
  localparam int CTW_APB_AW       = 3;
  localparam int CTW_APB_DW       = 32;

  // Signed working width for position arithmetic (covers 4096 plus sign).
  localparam int CTW_POS_W        = 15;

  localparam int CTW_WIDTH_RESET  = 640;
  localparam int CTW_HEIGHT_RESET = 480;

  // Register index, taken from paddr[2].
  typedef enum logic {
    CTW_REG_WIDTH  = 1'b0,
    CTW_REG_HEIGHT = 1'b1
  } ctw_reg_t;

  // Position of the window center that belongs to an incoming pixel.
  typedef struct packed {
    logic                 emit;
    logic [CTW_ROW_W-1:0] row;
    logic [CTW_COL_W-1:0] col;
  } ctw_pos_t;

endpackage

`default_nettype wire

FILE: sv/census_window_transform_top.sv
// ----------------------------------------------------------------------------
// census_window_transform_top
// Streaming census transform over a square window of grey pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ stream in raster order, one transfer per pixel;
// in_tuser marks the first pixel of a frame and restarts the position
// counters. For every interior center pixel one result leaves on the out_
// stream: the census code (one bit per neighbor, set when the center is
// greater than or equal to it, top-left neighbor in the MSB) with the
// center's row and column. Border pixels produce no transfer.
// An accepted pixel passes the update stage and then the output register.
// Throughput is one pixel per clock while the receiver keeps up: the line
// buffer RAM is read on accept and written back as the pixel leaves the
// update stage; a write to the column being read is forwarded, so any image width is handled.
// When the receiver stalls, one result waits in the output register and one
// more pixel can sit in the update stage; in_tready falls only when both are
// occupied and the held pixel produces a result.
// Reset clears the counters and the window and loads image_width = 640 and
// image_height = 480. The line buffer is not cleared; its rows are written
// before they are used in a result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module census_window_transform_top import ctw_pkg::*; #(
  parameter int WINDOW    = CTW_WINDOW,
  parameter int MAX_WIDTH = CTW_MAX_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // pixel [7:0]
  input  wire logic [CTW_PIXEL_W-1:0] in_tdata,
  // frame_start [0]
  input  wire logic                   in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // census_code [62:0], center_row [74:63], center_col [84:75], zero [87:85]
  output logic      [CTW_OUT_W-1:0]   out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CTW_APB_AW-1:0]  cfg_paddr,
  input  wire logic [CTW_APB_DW-1:0]  cfg_pwdata,
  output logic      [CTW_APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int LINES = WINDOW - 1;
  localparam int LW    = LINES * CTW_PIXEL_W;
  localparam int HALF  = WINDOW / 2;
  localparam int PADW  = CTW_OUT_W - CTW_CODE_W - CTW_ROW_W - CTW_COL_W;

  // Configuration registers.
  logic [CTW_WIDTH_W-1:0]  width_r;
  logic [CTW_HEIGHT_W-1:0] height_r;
  logic                    cfg_wr;
  ctw_reg_t                cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = ctw_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CTW_WIDTH_W'(CTW_WIDTH_RESET);
      height_r <= CTW_HEIGHT_W'(CTW_HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        CTW_REG_WIDTH:  width_r  <= cfg_pwdata[CTW_WIDTH_W-1:0];
        CTW_REG_HEIGHT: height_r <= cfg_pwdata[CTW_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      CTW_REG_WIDTH:  cfg_prdata = CTW_APB_DW'(width_r);
      CTW_REG_HEIGHT: cfg_prdata = CTW_APB_DW'(height_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Pipeline control.
  logic                   in_acc;
  logic                   s1_valid_r;
  ctw_pos_t               s1_info_r;
  logic [AW-1:0]          s1_addr_r;
  logic [CTW_PIXEL_W-1:0] s1_pixel_r;
  logic                   s1_adv;
  logic                   out_valid_r;
  logic [CTW_OUT_W-1:0]   out_data_r;

  ctw_pos_t               pos_info;
  logic [AW-1:0]          pos_addr;
  logic [LW-1:0]          ram_rdata;
  logic [LW-1:0]          ram_wdata;
  logic [CTW_CODE_W-1:0]  code;

  assign s1_adv    = s1_valid_r && (!s1_info_r.emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  ctw_pos #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (in_acc),
    .frame_start (in_tuser),
    .width_cfg   (width_r),
    .height_cfg  (height_r),
    .col_addr    (pos_addr),
    .info        (pos_info)
  );

  ctw_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data (ram_wdata),
    .rd_en   (in_acc),
    .rd_addr (pos_addr),
    .rd_data (ram_rdata)
  );

  ctw_window #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .rd_addr   (pos_addr),
    .s1_addr   (s1_addr_r),
    .commit    (s1_adv),
    .pixel     (s1_pixel_r),
    .ram_rdata (ram_rdata),
    .wr_data   (ram_wdata),
    .code      (code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_info_r  <= pos_info;
      s1_addr_r  <= pos_addr;
      s1_pixel_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_info_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_info_r.emit) begin
      out_data_r <= {PADW'(0), s1_info_r.col, s1_info_r.row, code};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Input backpressure only comes from a held result behind a stalled output.
  `ASSERT_IMP(a_ready_cause, clk, rst_n, !in_tready,
              s1_valid_r && s1_info_r.emit && out_valid_r && !out_tready)
  // A result leaving the update stage lands in the output register.
  `ASSERT_NEXT(a_result_lands, clk, rst_n, s1_adv && s1_info_r.emit, out_valid_r)
  // Results only belong to interior centers.
  `ASSERT_IMP(a_interior, clk, rst_n, out_valid_r,
              (out_data_r[CTW_CODE_W +: CTW_ROW_W] >= CTW_ROW_W'(HALF)) &&
              (out_data_r[CTW_CODE_W + CTW_ROW_W +: CTW_COL_W] >= CTW_COL_W'(HALF)))

endmodule

`default_nettype wire

FILE: sv/ctw_ram.sv
// ----------------------------------------------------------------------------
// ctw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/ctw_pos.sv
// ----------------------------------------------------------------------------
// ctw_pos
// Row and column counters, line buffer address and border decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ctw_pos import ctw_pkg::*; #(
  parameter int WINDOW    = CTW_WINDOW,
  parameter int MAX_WIDTH = CTW_MAX_WIDTH,
  localparam int AW       = $clog2(MAX_WIDTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    advance,
  input  wire logic                    frame_start,
  input  wire logic [CTW_WIDTH_W-1:0]  width_cfg,
  input  wire logic [CTW_HEIGHT_W-1:0] height_cfg,
  output logic      [AW-1:0]           col_addr,
  output ctw_pos_t                     info
);

  localparam int HALF = WINDOW / 2;
  localparam int LAG  = WINDOW - 1 - HALF;

  localparam logic signed [CTW_POS_W-1:0] ONE_S    = CTW_POS_W'(1);
  localparam logic signed [CTW_POS_W-1:0] LAG_S    = CTW_POS_W'(LAG);
  localparam logic signed [CTW_POS_W-1:0] LO_S     = CTW_POS_W'(LAG + HALF);
  localparam logic signed [CTW_POS_W-1:0] HI_OFF_S = CTW_POS_W'(LAG - HALF - 1);
  localparam logic signed [CTW_POS_W-1:0] MAXW_S   = CTW_POS_W'(MAX_WIDTH);

  logic [AW-1:0]        col_r, col_nxt, col_cur;
  logic [CTW_ROW_W-1:0] row_r, row_nxt, row_cur;

  logic signed [CTW_POS_W-1:0] w_ext, w_eff, h_eff;
  logic signed [CTW_POS_W-1:0] col_s, row_s, col_inc, row_inc;
  logic signed [CTW_POS_W-1:0] row_off, col_off;

  always_comb begin
    col_cur = frame_start ? '0 : col_r;
    row_cur = frame_start ? '0 : row_r;

    // Effective width clamps to 1 .. MAX_WIDTH, effective height is at least 1.
    w_ext = CTW_POS_W'(width_cfg);
    if (width_cfg == '0) begin
      w_eff = ONE_S;
    end else if (w_ext > MAXW_S) begin
      w_eff = MAXW_S;
    end else begin
      w_eff = w_ext;
    end
    h_eff = (height_cfg == '0) ? ONE_S : CTW_POS_W'(height_cfg);

    col_s   = CTW_POS_W'(col_cur);
    row_s   = CTW_POS_W'(row_cur);
    col_inc = col_s + ONE_S;
    row_inc = row_s + ONE_S;
    row_off = row_s - LAG_S;
    col_off = col_s - LAG_S;

    info.emit = (row_s >= LO_S) && (row_s <= h_eff + HI_OFF_S) &&
                (col_s >= LO_S) && (col_s <= w_eff + HI_OFF_S);
    info.row  = row_off[CTW_ROW_W-1:0];
    info.col  = col_off[CTW_COL_W-1:0];
    col_addr  = col_cur;

    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[CTW_ROW_W-1:0];
    end else begin
      col_nxt = col_inc[AW-1:0];
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ctw_window.sv
// ----------------------------------------------------------------------------
// ctw_window
// Line buffer column update with forwarding, window shift and census code.
// ----------------------------------------------------------------------------
`default_nettype none

module ctw_window import ctw_pkg::*; #(
  parameter int WINDOW    = CTW_WINDOW,
  parameter int MAX_WIDTH = CTW_MAX_WIDTH,
  localparam int AW       = $clog2(MAX_WIDTH),
  localparam int LINES    = WINDOW - 1,
  localparam int LW       = LINES * CTW_PIXEL_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire logic [AW-1:0]          rd_addr,
  input  wire logic [AW-1:0]          s1_addr,
  input  wire logic                   commit,
  input  wire logic [CTW_PIXEL_W-1:0] pixel,
  input  wire logic [LW-1:0]          ram_rdata,
  output logic      [LW-1:0]          wr_data,
  output logic      [CTW_CODE_W-1:0]  code
);

  localparam int HALF   = WINDOW / 2;
  localparam int NCELL  = WINDOW * WINDOW;
  localparam int NBITS  = NCELL - 1;
  localparam int CENTER = HALF * WINDOW + HALF;

  logic [CTW_PIXEL_W-1:0] win_r   [NCELL];
  logic [CTW_PIXEL_W-1:0] win_nxt [NCELL];
  logic [CTW_PIXEL_W-1:0] column  [WINDOW];
  logic [LW-1:0]          old_word;
  logic                   fwd_hit_r;
  logic [LW-1:0]          fwd_data_r;

  // The RAM reads old data when the item ahead writes the same column
  // in the cycle of the read, so that write is forwarded here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (load) begin
      fwd_hit_r <= commit && (s1_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    old_word = fwd_hit_r ? fwd_data_r : ram_rdata;
    // Slot 0 holds the oldest row; the new pixel enters at the top slot.
    wr_data  = {pixel, old_word[LW-1:CTW_PIXEL_W]};
    for (int r = 0; r < LINES; r++) begin
      column[r] = old_word[r*CTW_PIXEL_W +: CTW_PIXEL_W];
    end
    column[LINES] = pixel;
  end

  always_comb begin
    for (int r = 0; r < WINDOW; r++) begin
      for (int c = 0; c < WINDOW - 1; c++) begin
        win_nxt[r*WINDOW + c] = win_r[r*WINDOW + c + 1];
      end
      win_nxt[r*WINDOW + WINDOW - 1] = column[r];
    end
  end

  always_comb begin
    code = '0;
    for (int i = 0; i < NCELL; i++) begin
      if (i < CENTER) begin
        code[NBITS - 1 - i] = (win_nxt[CENTER] >= win_nxt[i]);
      end else if (i > CENTER) begin
        code[NBITS - i] = (win_nxt[CENTER] >= win_nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCELL; i++) begin
        win_r[i] <= '0;
      end
    end else if (commit) begin
      for (int i = 0; i < NCELL; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire
